### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Shared constants, character codes, sequencer states and control types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_LINES   = 25;
  localparam int CELL_W      = 16;
  localparam int TAB_STEP    = 4;

  localparam logic [7:0] RESET_ATTR = 8'hF0;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] BS_CODE    = 8'h08;
  localparam logic [7:0] TAB_CODE   = 8'h09;
  localparam logic [7:0] LF_CODE    = 8'h0A;
  localparam logic [7:0] CR_CODE    = 8'h0D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic write_cell;
    logic scroll;
  } cursor_ctl_t;

endpackage

### src/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tcw_addr_unit.sv
// ----------------------------------------------------------------------------
// Cell address unit
// Maps a screen row and column to a store address through the rotating top row.
// ----------------------------------------------------------------------------
module tcw_addr_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int LINES   = DEF_LINES
) (
  input  logic [$clog2(LINES)-1:0]         row,
  input  logic [$clog2(COLUMNS)-1:0]       col,
  input  logic [$clog2(LINES)-1:0]         top_row,
  output logic [$clog2(LINES*COLUMNS)-1:0] addr
);

  localparam int RowW  = $clog2(LINES);
  localparam int AddrW = $clog2(LINES*COLUMNS);

  logic [RowW:0]   row_sum;
  logic [RowW-1:0] phys_row;

  always_comb begin
    row_sum = {1'b0, row} + {1'b0, top_row};
    if (row_sum >= (RowW+1)'(LINES)) begin
      row_sum = row_sum - (RowW+1)'(LINES);
    end
    phys_row = row_sum[RowW-1:0];
    addr = AddrW'(phys_row) * AddrW'(COLUMNS) + AddrW'(col);
  end

endmodule

### src/tcw_cursor.sv
// ----------------------------------------------------------------------------
// Cursor update
// Applies one character code to the cursor and flags cell writes and scrolls.
// ----------------------------------------------------------------------------
module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int LINES   = DEF_LINES
) (
  input  logic [7:0]                 code,
  input  logic [$clog2(COLUMNS)-1:0] cur_col,
  input  logic [$clog2(LINES)-1:0]   cur_row,
  output logic [$clog2(COLUMNS)-1:0] new_col,
  output logic [$clog2(LINES)-1:0]   new_row,
  output cursor_ctl_t                ctl
);

  localparam int ColW = $clog2(COLUMNS);
  localparam int RowW = $clog2(LINES);

  logic [ColW:0] col_w;
  logic [RowW:0] row_w;

  always_comb begin
    col_w = {1'b0, cur_col};
    row_w = {1'b0, cur_row};
    ctl   = '0;
    case (code)
      TAB_CODE: begin
        col_w = ({1'b0, cur_col} + (ColW+1)'(TAB_STEP)) & ~((ColW+1)'(TAB_STEP-1));
      end
      CR_CODE: begin
        col_w = '0;
      end
      LF_CODE: begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      BS_CODE: begin
        if (cur_col != '0) begin
          col_w = col_w - 1'b1;
        end
      end
      default: begin
        if (code >= SPACE_CODE) begin
          ctl.write_cell = 1'b1;
          col_w = col_w + 1'b1;
        end
      end
    endcase
    if (col_w >= (ColW+1)'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end
    if (row_w >= (RowW+1)'(LINES)) begin
      ctl.scroll = 1'b1;
      row_w = (RowW+1)'(LINES-1);
    end
    new_col = col_w[ColW-1:0];
    new_row = row_w[RowW-1:0];
  end

endmodule

### src/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// Text console character writer
// A character or a read request in, one item out with the read cell and the cursor position.
// ----------------------------------------------------------------------------
// A put passes the execute state and, when it scrolls, the sweep state, which
// blanks the new bottom line cell by cell through the single store write
// port. A read passes the read and read-wait states unless the cell is
// outside the screen. The next item is accepted in the cycle after a result
// is loaded. After reset a clearing pass writes LINES*COLUMNS blank cells, one
// a cycle, while no item is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int LINES   = DEF_LINES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code, read_row, read_col
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cell_value, cursor_col, cursor_row
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int ColW  = $clog2(COLUMNS);
  localparam int RowW  = $clog2(LINES);
  localparam int Cells = LINES * COLUMNS;
  localparam int AddrW = $clog2(Cells);

  state_t               state_r, state_nxt;
  logic [ColW-1:0]      cur_col_r, cur_col_nxt;
  logic [RowW-1:0]      cur_row_r, cur_row_nxt;
  logic [RowW-1:0]      top_r, top_nxt;
  logic [ColW-1:0]      sweep_col_r, sweep_col_nxt;
  logic [RowW-1:0]      sweep_row_r, sweep_row_nxt;
  logic                 sweep_clear_r, sweep_clear_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           attr_r;
  logic [7:0]           code_r, code_nxt;
  logic [4:0]           req_row_r, req_row_nxt;
  logic [6:0]           req_col_r, req_col_nxt;
  logic [CELL_W-1:0]    cell_r, cell_nxt;
  logic [31:0]          out_data_r;
  logic                 load_out;
  logic                 in_range;
  logic [RowW:0]        top_inc;

  logic [RowW-1:0]      au_row;
  logic [ColW-1:0]      au_col;
  logic [AddrW-1:0]     au_addr;
  logic                 ram_we;
  logic [CELL_W-1:0]    ram_wdata;
  logic [CELL_W-1:0]    ram_rdata;

  logic [ColW-1:0]      new_col;
  logic [RowW-1:0]      new_row;
  cursor_ctl_t          cur_ctl;

  tcw_addr_unit #(.COLUMNS(COLUMNS), .LINES(LINES)) u_addr (
    .row     (au_row),
    .col     (au_col),
    .top_row (top_r),
    .addr    (au_addr)
  );

  tcw_cursor #(.COLUMNS(COLUMNS), .LINES(LINES)) u_cursor (
    .code    (code_r),
    .cur_col (cur_col_r),
    .cur_row (cur_row_r),
    .new_col (new_col),
    .new_row (new_row),
    .ctl     (cur_ctl)
  );

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(Cells)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (au_addr),
    .wdata (ram_wdata),
    .raddr (au_addr),
    .rdata (ram_rdata)
  );

  assign in_range = (32'(in_tdata[12:8]) < 32'(LINES)) &&
                    (32'(in_tdata[19:13]) < 32'(COLUMNS));
  assign top_inc  = {1'b0, top_r} + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    top_nxt         = top_r;
    sweep_col_nxt   = sweep_col_r;
    sweep_row_nxt   = sweep_row_r;
    sweep_clear_nxt = sweep_clear_r;
    code_nxt        = code_r;
    req_row_nxt     = req_row_r;
    req_col_nxt     = req_col_r;
    cell_nxt        = cell_r;
    in_tready       = 1'b0;
    load_out        = 1'b0;
    au_row          = cur_row_r;
    au_col          = cur_col_r;
    ram_we          = 1'b0;
    ram_wdata       = {attr_r, code_r};
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          code_nxt    = in_tdata[7:0];
          req_row_nxt = in_tdata[12:8];
          req_col_nxt = in_tdata[19:13];
          cell_nxt    = '0;
          if (!in_tuser) begin
            state_nxt = ST_EXEC;
          end else if (in_range) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_EXEC: begin
        ram_we      = cur_ctl.write_cell;
        cur_col_nxt = new_col;
        cur_row_nxt = new_row;
        if (cur_ctl.scroll) begin
          top_nxt         = (top_inc == (RowW+1)'(LINES)) ? '0 : top_inc[RowW-1:0];
          sweep_row_nxt   = RowW'(LINES-1);
          sweep_col_nxt   = '0;
          sweep_clear_nxt = 1'b0;
          state_nxt       = ST_SWEEP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SWEEP: begin
        au_row    = sweep_row_r;
        au_col    = sweep_col_r;
        ram_we    = 1'b1;
        ram_wdata = {(sweep_clear_r ? RESET_ATTR : attr_r), SPACE_CODE};
        if (sweep_col_r == ColW'(COLUMNS-1)) begin
          sweep_col_nxt = '0;
          if (sweep_clear_r && (sweep_row_r != RowW'(LINES-1))) begin
            sweep_row_nxt = sweep_row_r + 1'b1;
          end else begin
            state_nxt = sweep_clear_r ? ST_IDLE : ST_DONE;
          end
        end else begin
          sweep_col_nxt = sweep_col_r + 1'b1;
        end
      end
      ST_READ: begin
        au_row    = RowW'(req_row_r);
        au_col    = ColW'(req_col_r);
        state_nxt = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        cell_nxt  = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      top_r         <= '0;
      sweep_col_r   <= '0;
      sweep_row_r   <= '0;
      sweep_clear_r <= 1'b1;
      out_valid_r   <= 1'b0;
      attr_r        <= RESET_ATTR;
    end else begin
      state_r       <= state_nxt;
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      top_r         <= top_nxt;
      sweep_col_r   <= sweep_col_nxt;
      sweep_row_r   <= sweep_row_nxt;
      sweep_clear_r <= sweep_clear_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r    <= code_nxt;
    req_row_r <= req_row_nxt;
    req_col_r <= req_col_nxt;
    cell_r    <= cell_nxt;
    if (load_out) begin
      out_data_r <= {4'b0, 5'(cur_row_r), 7'(cur_col_r), cell_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
